### sv/wfiv_pkg.sv
// shared types and constants for the frame integrity check verifier
`timescale 1ns / 1ps
package wfiv_pkg;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [7:0]  SNAP_BYTE = 8'hAA;
    localparam int unsigned LONG_SECRET_LEN = 13;

    localparam logic [1:0] REG_SECRET_LOW  = 2'd0;
    localparam logic [1:0] REG_SECRET_HIGH = 2'd1;
    localparam logic [1:0] REG_LONG_MODE   = 2'd2;
    localparam logic [1:0] REG_BSSID       = 2'd3;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH = 64;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [23:0] init_vector;
        logic [47:0] frame_bssid;
        logic        last_frame;
    } in_item_t;

    typedef struct packed {
        logic        frame_matched;
        logic        frame_good;
        logic [31:0] good_total;
        logic [31:0] bad_total;
        logic        key_accepted;
        logic        set_done;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch input item, start frame if first
        logic init_step;   // identity fill of one table entry
        logic ksa_rd;      // schedule: read s[n]
        logic ksa_rdj;     // schedule: read s[j]
        logic ksa_wr;      // schedule: swap
        logic prga_rdi;    // stream: read s[i]
        logic prga_rdj;    // stream: read s[j]
        logic prga_wr;     // stream: write s[i]
        logic prga_wrj;    // stream: write s[j], read sum
        logic prga_fin;    // stream: use key byte
        logic finish;      // build result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ours;        // frame is matched
        logic cnt_last;    // sweep counter at 255
        logic first;
        logic last;
    } dp_stat_t;

    function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction
endpackage

### sv/wfiv_stream_if.sv
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps
interface wfiv_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### sv/wfiv_datapath.sv
// permutation table, key schedule, keystream, crc and tallies
`timescale 1ns / 1ps
module wfiv_datapath #(
    parameter int TALLY_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wfiv_pkg::dp_cmd_t   cmd,
    output wfiv_pkg::dp_stat_t  stat,
    input  wfiv_pkg::in_item_t  in_item,
    output wfiv_pkg::out_item_t out_item,
    input  logic [63:0]         secret_low,
    input  logic [39:0]         secret_high,
    input  logic                long_key_mode,
    input  logic [47:0]         station_bssid
);
    import wfiv_pkg::*;

    localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = {TALLY_WIDTH{1'b1}};

    logic [7:0] perm_mem [256];
    logic [7:0] rd_data_reg;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr, wr_data;

    in_item_t   item_reg;
    logic [7:0] cnt_reg;
    logic [7:0] idx_i_reg, idx_j_reg;
    logic [7:0] si_reg, sj_reg;
    logic [7:0] ks_j;
    logic [7:0] key_byte;
    logic [3:0] key_pos;
    logic [7:0] sum_addr;
    logic [7:0] ks_byte;
    logic [7:0] plain;
    logic [31:0] crc_reg, tail_reg;
    logic [2:0] pos_reg;
    logic [1:0] snap_reg;
    logic       ours_reg;
    logic [TALLY_WIDTH-1:0] good_reg, bad_reg, good_next, bad_next;
    logic       good;
    logic [1:0] wr_phase_reg;

    // key byte for position n mod len
    always_comb
    begin
        key_pos = long_key_mode ? cnt_reg[3:0] : {1'b0, cnt_reg[2:0]};
        unique case (key_pos)
            4'd0: key_byte = item_reg.init_vector[7:0];
            4'd1: key_byte = item_reg.init_vector[15:8];
            4'd2: key_byte = item_reg.init_vector[23:16];
            4'd3: key_byte = secret_low[7:0];
            4'd4: key_byte = secret_low[15:8];
            4'd5: key_byte = secret_low[23:16];
            4'd6: key_byte = secret_low[31:24];
            4'd7: key_byte = secret_low[39:32];
            4'd8: key_byte = secret_low[47:40];
            4'd9: key_byte = secret_low[55:48];
            4'd10: key_byte = secret_low[63:56];
            4'd11: key_byte = secret_high[7:0];
            4'd12: key_byte = secret_high[15:8];
            4'd13: key_byte = secret_high[23:16];
            4'd14: key_byte = secret_high[31:24];
            4'd15: key_byte = secret_high[39:32];
            default: key_byte = 8'd0;
        endcase
        // short mode: key bytes 8..15 unused since len 8
    end

    assign ks_j = idx_j_reg + rd_data_reg + key_byte;
    assign sum_addr = si_reg + sj_reg;

    always_comb
    begin
        rd_addr = cnt_reg;
        wr_en = 1'b0;
        wr_addr = cnt_reg;
        wr_data = cnt_reg;
        if (cmd.init_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.ksa_rdj)
        begin
            rd_addr = ks_j;
        end
        else if (cmd.ksa_wr)
        begin
            wr_en = 1'b1;
            if (wr_phase_reg == 2'd0)
            begin
                wr_addr = cnt_reg;
                wr_data = rd_data_reg;
            end
            else
            begin
                wr_addr = idx_j_reg;
                wr_data = si_reg;
            end
        end
        else if (cmd.prga_rdi)
        begin
            rd_addr = idx_i_reg + 8'd1;
        end
        else if (cmd.prga_rdj)
        begin
            rd_addr = idx_j_reg + rd_data_reg;
        end
        else if (cmd.prga_wr)
        begin
            wr_en = 1'b1;
            wr_addr = idx_i_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.prga_wrj)
        begin
            wr_en = 1'b1;
            wr_addr = idx_j_reg;
            wr_data = si_reg;
            rd_addr = sum_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            perm_mem[wr_addr] <= wr_data;
        rd_data_reg <= perm_mem[rd_addr];
    end

    // sum read shares the edge with the s[j] write
    assign ks_byte = (sum_addr == idx_j_reg) ? si_reg : rd_data_reg;
    assign plain = item_reg.data_byte ^ ks_byte;

    always_comb
    begin
        good = ours_reg && (pos_reg == 3'd4) && ((crc_reg ^ CRC_ONES) == tail_reg)
            && (snap_reg == 2'd2);
        good_next = good_reg;
        bad_next = bad_reg;
        if (ours_reg)
        begin
            if (good)
            begin
                if (good_reg != TALLY_MAX)
                    good_next = good_reg + 1'b1;
            end
            else if (bad_reg != TALLY_MAX)
            begin
                bad_next = bad_reg + 1'b1;
            end
        end
    end

    // ksa_wr swaps in two writes: s[n] <= s[j] then s[j] <= s[n]
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.load && in_item.first_byte)
        begin
            idx_i_reg <= '0;
            idx_j_reg <= '0;
        end
        if (cmd.ksa_rd)
            si_reg <= 8'd0;
        if (cmd.ksa_rdj)
        begin
            si_reg <= rd_data_reg;
            idx_j_reg <= ks_j;
        end
        if (cmd.ksa_wr && wr_phase_reg == 2'd1 && cnt_reg == 8'd255)
            idx_j_reg <= '0;
        if (cmd.prga_rdj)
        begin
            si_reg <= rd_data_reg;
            idx_i_reg <= idx_i_reg + 8'd1;
            idx_j_reg <= idx_j_reg + rd_data_reg;
        end
        if (cmd.finish)
        begin
            out_item.frame_matched <= ours_reg;
            out_item.frame_good <= good;
            out_item.good_total <= 32'(good_next);
            out_item.bad_total <= 32'(bad_next);
            out_item.key_accepted <= good_next > bad_next;
            out_item.set_done <= item_reg.last_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ours_reg <= 1'b0;
            crc_reg <= CRC_ONES;
            tail_reg <= '0;
            pos_reg <= '0;
            snap_reg <= '0;
            good_reg <= '0;
            bad_reg <= '0;
            wr_phase_reg <= '0;
            sj_reg <= '0;
        end
        else
        begin
            if (cmd.load && in_item.first_byte)
            begin
                ours_reg <= in_item.frame_bssid == station_bssid;
                crc_reg <= CRC_ONES;
                tail_reg <= '0;
                pos_reg <= '0;
                snap_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.init_step || (cmd.ksa_wr && wr_phase_reg == 2'd1))
                cnt_reg <= cnt_reg + 8'd1;
            if (cmd.ksa_wr)
                wr_phase_reg <= wr_phase_reg + 2'd1;
            else
                wr_phase_reg <= '0;
            if (cmd.prga_wr)
                sj_reg <= rd_data_reg;
            if (cmd.prga_fin)
            begin
                if (pos_reg == 3'd0)
                    snap_reg <= (plain == SNAP_BYTE) ? 2'd1 : 2'd0;
                else if (pos_reg == 3'd1 && snap_reg == 2'd1 && plain == SNAP_BYTE)
                    snap_reg <= 2'd2;
                if (pos_reg == 3'd4)
                    crc_reg <= crc_byte(crc_reg, tail_reg[7:0]);
                tail_reg <= {plain, tail_reg[31:8]};
                if (pos_reg != 3'd4)
                    pos_reg <= pos_reg + 3'd1;
            end
            if (cmd.finish)
            begin
                ours_reg <= 1'b0;
                good_reg <= item_reg.last_frame ? '0 : good_next;
                bad_reg <= item_reg.last_frame ? '0 : bad_next;
            end
        end
    end

    assign stat.ours = ours_reg;
    assign stat.cnt_last = cnt_reg == 8'd255;
    assign stat.first = item_reg.first_byte;
    assign stat.last = item_reg.last_byte;
endmodule

### sv/wfiv_controller.sv
// sequencer for the key schedule, keystream and result hand-off
`timescale 1ns / 1ps
module wfiv_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output wfiv_pkg::dp_cmd_t  cmd,
    input  wfiv_pkg::dp_stat_t stat
);
    import wfiv_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CHECK = 12'b000000000010,
        S_FILL  = 12'b000000000100,
        S_KRD   = 12'b000000001000,
        S_KRDJ  = 12'b000000010000,
        S_KWR   = 12'b000000100000,
        S_RDI   = 12'b000001000000,
        S_RDJ   = 12'b000010000000,
        S_WR    = 12'b000100000000,
        S_WRJ   = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   kwr_second_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.first && stat.ours)
                    state_next = S_FILL;
                else if (stat.ours)
                    state_next = S_RDI;
                else
                    state_next = S_DONE;
            end
            S_FILL:
            begin
                cmd.init_step = 1'b1;
                if (stat.cnt_last)
                    state_next = S_KRD;
            end
            S_KRD:
            begin
                cmd.ksa_rd = 1'b1;
                state_next = S_KRDJ;
            end
            S_KRDJ:
            begin
                cmd.ksa_rdj = 1'b1;
                state_next = S_KWR;
            end
            S_KWR:
            begin
                cmd.ksa_wr = 1'b1;
                if (kwr_second_reg)
                    state_next = stat.cnt_last ? S_RDI : S_KRD;
            end
            S_RDI:
            begin
                cmd.prga_rdi = 1'b1;
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                cmd.prga_rdj = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.prga_wr = 1'b1;
                state_next = S_WRJ;
            end
            S_WRJ:
            begin
                cmd.prga_wrj = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.prga_fin = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.last)
                    state_next = S_IDLE;
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            kwr_second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            kwr_second_reg <= (state_reg == S_KWR) && !kwr_second_reg;
        end
    end
endmodule

### sv/wep_frame_icv_verifier.sv
// top level of the frame integrity check verifier
`timescale 1ns / 1ps
// Takes one encrypted frame byte per transfer and returns one result on each
// frame's last byte. A byte of a matched frame needs three dependent table
// reads and a two-write swap on the permutation memory (one read port, one
// write port); the first byte of a matched frame adds a fill of all 256 table
// entries and a key schedule over every entry. Other frames skip the table.
// A pending result does not block the next byte until the result register
// is needed again.
module wep_frame_icv_verifier #(
    parameter int TALLY_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    wfiv_stream_if.sink   in_ch,
    wfiv_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [wfiv_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [wfiv_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import wfiv_pkg::*;

    logic [63:0] secret_low_reg;
    logic [39:0] secret_high_reg;
    logic        long_key_mode_reg;
    logic [47:0] station_bssid_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_low_reg <= '0;
            secret_high_reg <= '0;
            long_key_mode_reg <= 1'b0;
            station_bssid_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SECRET_LOW:  secret_low_reg <= cfg_data;
                REG_SECRET_HIGH: secret_high_reg <= cfg_data[39:0];
                REG_LONG_MODE:   long_key_mode_reg <= cfg_data[0];
                REG_BSSID:       station_bssid_reg <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    wfiv_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    wfiv_datapath #(.TALLY_WIDTH(TALLY_WIDTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_item       (in_ch.payload),
        .out_item      (out_ch.payload),
        .secret_low    (secret_low_reg),
        .secret_high   (secret_high_reg),
        .long_key_mode (long_key_mode_reg),
        .station_bssid (station_bssid_reg)
    );

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd)) else $error("more than one datapath command");
    a_result_vs_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !in_ch.ready) else $error("input taken during result");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
`endif
endmodule

### tb/sv/wep_frame_icv_verifier_tb.sv
// self-checking testbench for the frame integrity check verifier
`timescale 1ns / 1ps
module wep_frame_icv_verifier_tb;
    import wfiv_pkg::*;

    localparam longint unsigned TALLY_MAX = 64'hFFFF_FFFF;
    localparam longint unsigned CYCLE_LIMIT = 40_000_000;
    localparam int SETTLE_CYCLES = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_SECRET_LOW;
    logic [63:0] cfg_data = '0;

    wfiv_stream_if #(.payload_t(in_item_t)) in_if ();
    wfiv_stream_if #(.payload_t(out_item_t)) out_if ();

    wep_frame_icv_verifier DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_if.sink),
        .out_ch(out_if.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register copies
    logic [63:0] key_low;
    logic [39:0] key_high;
    logic        key_long;
    logic [47:0] own_bssid;

    // rc4 state: set 0 follows the block, set 1 builds frames
    logic [7:0] perm [2][256];
    logic [7:0] pos_i [2];
    logic [7:0] pos_j [2];

    logic [31:0] crc_run;
    logic [31:0] icv_window;
    logic [2:0]  seen_bytes;
    logic [1:0]  snap_state;
    logic        frame_ours;
    longint unsigned good_count;
    longint unsigned bad_count;

    in_item_t  byte_queue [$];
    out_item_t verdict_queue [$];
    int  queued_bytes = 0;
    int  sent_bytes = 0;
    bit  failed = 1'b0;
    bit  idle_on = 1'b1;
    int  send_gap = 0;
    int  take_gap = 0;
    longint unsigned cycles = 0;

    function automatic logic [31:0] crc_update(logic [31:0] c_in, logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    function void rc4_init(int u, logic [23:0] iv);
        logic [7:0] key [16];
        int len;
        logic [7:0] j;
        logic [7:0] t;
        for (int n = 0; n < 16; n++)
            key[n] = 8'd0;
        key[0] = iv[7:0];
        key[1] = iv[15:8];
        key[2] = iv[23:16];
        len = key_long ? 16 : 8;
        for (int n = 0; n < (key_long ? LONG_SECRET_LEN : 5); n++)
            key[3 + n] = (n < 8) ? key_low[8 * n +: 8] : key_high[8 * (n - 8) +: 8];
        for (int n = 0; n < 256; n++)
            perm[u][n] = n[7:0];
        j = 8'd0;
        for (int n = 0; n < 256; n++)
        begin
            j = j + perm[u][n] + key[n % len];
            t = perm[u][n];
            perm[u][n] = perm[u][j];
            perm[u][j] = t;
        end
        pos_i[u] = 8'd0;
        pos_j[u] = 8'd0;
    endfunction

    function logic [7:0] rc4_next(int u);
        logic [7:0] t;
        pos_i[u] = pos_i[u] + 8'd1;
        pos_j[u] = pos_j[u] + perm[u][pos_i[u]];
        t = perm[u][pos_i[u]];
        perm[u][pos_i[u]] = perm[u][pos_j[u]];
        perm[u][pos_j[u]] = t;
        return perm[u][perm[u][pos_i[u]] + perm[u][pos_j[u]]];
    endfunction

    function void predict_verdict(in_item_t it);
        logic [7:0] plain;
        out_item_t r;
        bit good;
        if (it.first_byte)
        begin
            frame_ours = (it.frame_bssid == own_bssid);
            crc_run = CRC_ONES;
            icv_window = '0;
            seen_bytes = '0;
            snap_state = '0;
            if (frame_ours)
                rc4_init(0, it.init_vector);
        end
        if (frame_ours)
        begin
            plain = it.data_byte ^ rc4_next(0);
            if (seen_bytes == 0)
                snap_state = (plain == SNAP_BYTE) ? 2'd1 : 2'd0;
            else if (seen_bytes == 1 && snap_state == 2'd1 && plain == SNAP_BYTE)
                snap_state = 2'd2;
            if (seen_bytes >= 4)
                crc_run = crc_update(crc_run, icv_window[7:0]);
            icv_window = {plain, icv_window[31:8]};
            if (seen_bytes < 4)
                seen_bytes = seen_bytes + 3'd1;
        end
        if (!it.last_byte)
            return;
        good = 1'b0;
        if (frame_ours)
        begin
            good = seen_bytes >= 4 && (crc_run ^ CRC_ONES) == icv_window && snap_state == 2'd2;
            if (good)
            begin
                if (good_count < TALLY_MAX)
                    good_count++;
            end
            else if (bad_count < TALLY_MAX)
                bad_count++;
        end
        r.frame_matched = frame_ours;
        r.frame_good = good;
        r.good_total = good_count[31:0];
        r.bad_total = bad_count[31:0];
        r.key_accepted = good_count > bad_count;
        r.set_done = it.last_frame;
        verdict_queue.push_back(r);
        frame_ours = 1'b0;
        if (it.last_frame)
        begin
            good_count = 0;
            bad_count = 0;
        end
    endfunction

    function void queue_byte(logic [7:0] d, bit f, bit l, logic [23:0] iv,
                             logic [47:0] bssid, bit lf);
        in_item_t it;
        it.data_byte = d;
        it.first_byte = f;
        it.last_byte = l;
        it.init_vector = f ? iv : 24'($urandom);
        it.frame_bssid = f ? bssid : {16'($urandom), 32'($urandom)};
        it.last_frame = lf;
        byte_queue.push_back(it);
        queued_bytes++;
    endfunction

    // flaw: 0 clean, 1 broken icv, 2 broken snap
    function void queue_frame(bit matched, int len, int flaw, bit lf);
        logic [7:0] plain [$];
        logic [23:0] iv;
        logic [47:0] bssid;
        logic [31:0] c;
        int k;
        iv = 24'($urandom);
        if (matched)
            bssid = own_bssid;
        else if ($urandom_range(0, 1))
            bssid = own_bssid ^ (48'd1 << $urandom_range(0, 47));
        else
            bssid = {16'($urandom), 32'($urandom)};
        if (bssid == own_bssid && !matched)
            bssid = ~own_bssid;
        plain = {};
        if (len >= 6)
        begin
            plain.push_back(SNAP_BYTE);
            plain.push_back(SNAP_BYTE);
            for (k = 2; k < len - 4; k++)
                plain.push_back(8'($urandom));
            c = CRC_ONES;
            foreach (plain[n])
                c = crc_update(c, plain[n]);
            c = c ^ CRC_ONES;
            for (k = 0; k < 4; k++)
                plain.push_back(c[8 * k +: 8]);
            if (flaw == 1)
                plain[$urandom_range(2, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
            else if (flaw == 2)
                plain[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        else
            for (k = 0; k < len; k++)
                plain.push_back(8'($urandom));
        rc4_init(1, iv);
        foreach (plain[n])
            queue_byte(plain[n] ^ rc4_next(1), n == 0, n == len - 1, iv, bssid, lf);
    endfunction

    task write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SECRET_LOW:  key_low = val;
            REG_SECRET_HIGH: key_high = val[39:0];
            REG_LONG_MODE:   key_long = val[0];
            REG_BSSID:       own_bssid = val[47:0];
            default: ;
        endcase
    endtask

    task write_all(logic [63:0] lo, logic [63:0] hi, logic [63:0] md, logic [63:0] bs);
        write_reg(REG_SECRET_LOW, lo);
        write_reg(REG_SECRET_HIGH, hi);
        write_reg(REG_LONG_MODE, md);
        write_reg(REG_BSSID, bs);
    endtask

    task wait_drained();
        do
            @(negedge clk);
        while (sent_bytes != queued_bytes || verdict_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function void queue_random_frame();
        int r;
        int len;
        int nb;
        bit lf;
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(6, 16);
        lf = ($urandom_range(0, 7) == 0);
        if (r < 55)
            queue_frame(1'b1, len, 0, lf);
        else if (r < 67)
            queue_frame(1'b1, len, 1, lf);
        else if (r < 75)
            queue_frame(1'b1, len, 2, lf);
        else if (r < 82)
            queue_frame(1'b1, $urandom_range(1, 5), 0, lf);
        else if (r < 92)
            queue_frame(1'b0, $urandom_range(1, 12), 0, lf);
        else if (r < 96)
        begin
            // bytes outside any frame
            nb = $urandom_range(1, 3);
            for (int k = 0; k < nb; k++)
                queue_byte(8'($urandom), 1'b0, k == nb - 1, 24'd0, 48'd0, lf);
        end
        else
        begin
            // frame cut short by a new first byte
            queue_frame(1'b1, $urandom_range(2, 6), 0, lf);
            void'(byte_queue.pop_back());
            queued_bytes--;
            queue_frame(1'b1, len, 0, lf);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
            in_if.payload <= '0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                predict_verdict(in_if.payload);
                sent_bytes++;
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    in_if.valid <= 1'b1;
                    in_if.payload <= byte_queue.pop_front();
                    send_gap = pick_gap();
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_if.payload);
                    failed = 1'b1;
                end
                else
                begin
                    out_item_t e;
                    out_item_t a;
                    e = verdict_queue.pop_front();
                    a = out_if.payload;
                    if (a.frame_matched !== e.frame_matched)
                    begin
                        $display("%0t: frame_matched expected %0d actual %0d",
                                 $time, e.frame_matched, a.frame_matched);
                        failed = 1'b1;
                    end
                    if (a.frame_good !== e.frame_good)
                    begin
                        $display("%0t: frame_good expected %0d actual %0d",
                                 $time, e.frame_good, a.frame_good);
                        failed = 1'b1;
                    end
                    if (a.good_total !== e.good_total)
                    begin
                        $display("%0t: good_total expected %0d actual %0d",
                                 $time, e.good_total, a.good_total);
                        failed = 1'b1;
                    end
                    if (a.bad_total !== e.bad_total)
                    begin
                        $display("%0t: bad_total expected %0d actual %0d",
                                 $time, e.bad_total, a.bad_total);
                        failed = 1'b1;
                    end
                    if (a.key_accepted !== e.key_accepted)
                    begin
                        $display("%0t: key_accepted expected %0d actual %0d",
                                 $time, e.key_accepted, a.key_accepted);
                        failed = 1'b1;
                    end
                    if (a.set_done !== e.set_done)
                    begin
                        $display("%0t: set_done expected %0d actual %0d",
                                 $time, e.set_done, a.set_done);
                        failed = 1'b1;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
                take_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("wep_frame_icv_verifier test failed");
            $finish;
        end
    end

    initial
    begin
        key_low = '0;
        key_high = '0;
        key_long = 1'b0;
        own_bssid = '0;
        crc_run = CRC_ONES;
        icv_window = '0;
        seen_bytes = '0;
        snap_state = '0;
        frame_ours = 1'b0;
        good_count = 0;
        bad_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration, short key
        queue_frame(1'b1, 8, 0, 1'b0);
        queue_frame(1'b1, 8, 1, 1'b0);
        queue_frame(1'b1, 7, 2, 1'b0);
        queue_frame(1'b1, 1, 0, 1'b0);
        queue_frame(1'b1, 2, 0, 1'b0);
        queue_frame(1'b1, 3, 0, 1'b0);
        queue_frame(1'b1, 4, 0, 1'b1);
        wait_drained();

        // all-ones extremes, long key
        write_all('1, '1, '1, '1);
        queue_frame(1'b1, 6, 0, 1'b0);
        queue_frame(1'b0, 3, 0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1, 24'd0, 48'd0, 1'b0);
        queue_frame(1'b1, 6, 0, 1'b1);
        wait_drained();

        while (queued_bytes < 1950)
        begin
            idle_on = $urandom_range(0, 3) != 0;
            write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
            for (int k = 0; k < 20; k++)
                queue_random_frame();
            queue_frame(1'b1, 6, 0, 1'b1);
            wait_drained();
        end

        if (!failed)
            $display("wep_frame_icv_verifier test passed");
        else
            $display("wep_frame_icv_verifier test failed");
        $finish;
    end
endmodule
